// ----- rtl/core/rmfw_pkg.sv -----
// Shared types and codes for the recursive mutex with its FIFO of waiting tasks.
package rmfw_pkg;

	typedef logic [3:0] task_t;

	typedef enum logic {
		REQ_ACQUIRE = 1'b0,
		REQ_RELEASE = 1'b1
	} req_kind_t;

	typedef enum logic [2:0] {
		ST_GRANTED   = 3'd0,
		ST_NESTED    = 3'd1,
		ST_QUEUED    = 3'd2,
		ST_NEST_REL  = 3'd3,
		ST_HANDOVER  = 3'd4,
		ST_FREED     = 3'd5,
		ST_NOT_OWNER = 3'd6,
		ST_OVERFLOW  = 3'd7
	} status_t;

	typedef struct packed {
		req_kind_t req_type;
		task_t     task_id;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic       woken_valid;
		task_t      woken_task;
		logic       held_now;
		task_t      owner_now;
		logic [7:0] nest_now;
	} res_t;

	typedef struct packed {
		logic push;
		logic pop;
	} qctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

endpackage

// ----- rtl/core/rmfw_cell.sv -----
// One slot of the waiter queue: loads a new task or takes its neighbor's on a pop.
module rmfw_cell import rmfw_pkg::*; (
	input  logic  clk,
	input  logic  load,
	input  logic  shift,
	input  task_t load_task,
	input  task_t next_task,
	output task_t data
);

	task_t data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_task;
		end else if (shift) begin
			data_q <= next_task;
		end
	end

	assign data = data_q;

endmodule

// ----- rtl/core/rmfw_queue.sv -----
// Waiter FIFO built as a row of shifting cells with an occupancy count.
module rmfw_queue import rmfw_pkg::*; #(
	parameter int MAX_TASKS = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	input  qctl_t  ctl,
	input  task_t  push_task,
	output qstat_t stat,
	output task_t  head
);

	localparam int CW = $clog2(MAX_TASKS + 1);

	logic [CW-1:0] count_q;
	task_t         cell_data [MAX_TASKS];

	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		task_t nbr;
		if (i == MAX_TASKS - 1) begin : g_last
			assign nbr = cell_data[i];
		end else begin : g_mid
			assign nbr = cell_data[i+1];
		end

		rmfw_cell u_cell (
			.clk      (clk),
			.load     (ctl.push && (count_q == CW'(i))),
			.shift    (ctl.pop),
			.load_task(push_task),
			.next_task(nbr),
			.data     (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.push) begin
			count_q <= count_q + CW'(1);
		end else if (ctl.pop) begin
			count_q <= count_q - CW'(1);
		end
	end

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CW'(MAX_TASKS));
	assign head       = cell_data[0];

	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.push && ctl.pop)) else $error("queue push and pop together");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> !stat.full) else $error("push into full queue");
	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |=> count_q == $past(count_q) - CW'(1))
		else $error("pop did not lower count");

endmodule

// ----- rtl/core/recursive_mutex_fifo_waiters_unit.sv -----
// Recursive mutex with FIFO wait queue: top level with lock state and request decode.
//
// Usage:
//  - Request channel: drive req (req_type, task_id) with start high; the word
//    is taken at the rising edge where start is high and busy is low. busy
//    stays low, so a new request may be issued in every cycle.
//  - Result channel: one result word per request, shown on res for exactly
//    one cycle with done high, in the cycle after the request was taken.
//    The receiver cannot stall; it must capture the word while done is high.
//  - Throughput is one request per cycle: the decision is a few compares on
//    the lock registers plus one push into or one shift of the waiter row.
//  - Reset (arst_n low) frees the lock, clears owner and nesting count and
//    empties the queue; no clearing pass is needed.
//  - Waiters are kept in a row of MAX_TASKS cells; a handover shifts every
//    cell one place toward the head in the same cycle.
//  - owner_now and nest_now read zero while the lock is free.
module recursive_mutex_fifo_waiters_unit import rmfw_pkg::*; #(
	parameter int MAX_TASKS = 16,
	parameter int MAX_NEST  = 255
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output res_t res
);

	localparam int NW = $clog2(MAX_NEST + 1);

	logic          held_q;
	task_t         owner_q;
	logic [NW-1:0] nest_q;
	logic          done_q;
	res_t          res_q;

	logic          take;
	logic          held_d;
	task_t         owner_d;
	logic [NW-1:0] nest_d;
	status_t       status_d;
	logic          woken_v_d;
	task_t         woken_t_d;
	qctl_t         qctl;
	qstat_t        qstat;
	task_t         head_task;
	res_t          res_d;

	assign busy = 1'b0;
	assign take = start && !busy;

	rmfw_queue #(.MAX_TASKS(MAX_TASKS)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (qctl),
		.push_task(req.task_id),
		.stat     (qstat),
		.head     (head_task)
	);

	// next lock state and queue control
	always_comb begin
		held_d    = held_q;
		owner_d   = owner_q;
		nest_d    = nest_q;
		status_d  = ST_NOT_OWNER;
		woken_v_d = 1'b0;
		woken_t_d = '0;
		qctl      = '0;
		if (req.req_type == REQ_ACQUIRE) begin
			if (!held_q) begin
				held_d   = 1'b1;
				owner_d  = req.task_id;
				nest_d   = '0;
				status_d = ST_GRANTED;
			end else if (owner_q == req.task_id) begin
				if (nest_q == NW'(MAX_NEST)) begin
					status_d = ST_OVERFLOW;
				end else begin
					nest_d   = nest_q + NW'(1);
					status_d = ST_NESTED;
				end
			end else if (qstat.full) begin
				status_d = ST_OVERFLOW;
			end else begin
				qctl.push = take;
				status_d  = ST_QUEUED;
			end
		end else begin
			if (!held_q || owner_q != req.task_id) begin
				status_d = ST_NOT_OWNER;
			end else if (nest_q != '0) begin
				nest_d   = nest_q - NW'(1);
				status_d = ST_NEST_REL;
			end else if (!qstat.empty) begin
				qctl.pop  = take;
				owner_d   = head_task;
				nest_d    = '0;
				woken_v_d = 1'b1;
				woken_t_d = head_task;
				status_d  = ST_HANDOVER;
			end else begin
				held_d   = 1'b0;
				owner_d  = '0;
				nest_d   = '0;
				status_d = ST_FREED;
			end
		end
	end

	// result word
	always_comb begin
		res_d.status      = status_d;
		res_d.woken_valid = woken_v_d;
		res_d.woken_task  = woken_t_d;
		res_d.held_now    = held_d;
		res_d.owner_now   = held_d ? owner_d : '0;
		res_d.nest_now    = held_d ? 8'(nest_d) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 1'b0;
			owner_q <= '0;
			nest_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= take;
			if (take) begin
				held_q  <= held_d;
				owner_q <= owner_d;
				nest_q  <= nest_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

	assign done = done_q;
	assign res  = res_q;

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> done) else $error("request without result");
	a_handover_held: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.status == ST_HANDOVER |-> res.woken_valid && res.held_now
		&& res.owner_now == res.woken_task) else $error("bad handover word");
	a_free_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done && !res.held_now |-> res.owner_now == '0 && res.nest_now == '0)
		else $error("free lock reports owner");
	a_queued_held: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.status == ST_QUEUED |-> res.held_now && $past(held_q))
		else $error("queued while lock free");

endmodule
